// ===== src/chv_pkg.sv =====
package chv_pkg;

  localparam int unsigned IDX_W = 33;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Magic bytes 'W','V','B','F' read little-endian
  localparam logic [31:0] MAGIC_WORD = 32'h4642_5657;
  localparam logic [15:0] MAX_SECTIONS = 16'd128;
  localparam logic [7:0] MAX_VERSION = 8'd2;
  localparam logic [IDX_W-1:0] HDR_LEN = 33'd24;
  localparam logic [IDX_W-1:0] HASHED_LEN = 33'd20;
  localparam logic [31:0] HASHED_LEN_WORD = 32'd20;

  // Header byte positions at which each check fires
  localparam logic [IDX_W-1:0] POS_MAGIC = 33'd3;
  localparam logic [IDX_W-1:0] POS_VERSION = 33'd4;
  localparam logic [IDX_W-1:0] POS_SECTIONS = 33'd7;
  localparam logic [IDX_W-1:0] POS_HDR_SUM = 33'd23;

  // Offsets reported with each error
  localparam logic [4:0] OFS_NONE = 5'd0;
  localparam logic [4:0] OFS_VERSION = 5'd4;
  localparam logic [4:0] OFS_SECTIONS = 5'd6;
  localparam logic [4:0] OFS_DIR_LEN = 5'd8;
  localparam logic [4:0] OFS_BODY_SUM = 5'd16;
  localparam logic [4:0] OFS_HDR_SUM = 5'd20;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EOF      = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_HDR_SUM  = 3'd5,
    ST_BODY_SUM = 3'd6
  } status_t;

  // One FNV-1a step; product truncated to 32 bits
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] x;
    x = h ^ v;
    return x * FNV_PRIME;
  endfunction

endpackage

// ===== src/container_header_validator.sv =====
// Container header validator.
//
// Input channel (s_axis_*): one file byte per beat, s_axis_tlast on the final
// byte of the file. Output channel (m_axis_*): one verdict beat per file,
// carrying status, error offset and the header fields as read.
//
// Every accepted byte updates, where it lies in their byte ranges, the header
// capture, the header FNV-1a hash and the directory-body FNV-1a hash in the
// same cycle. The final byte snapshots the verdict inputs into a prep register;
// the next stage folds the directory size into the body hash (one constant
// multiply), compares it and loads the output register, which drives
// m_axis_tdata. Input takes one byte per cycle while s_axis_tready is high;
// a new file may start right behind a verdict.
//
// Reset clears the byte count, header capture and all valid flags; hashes get FNV_BASIS.
// When the receiver stalls, the verdict holds in the output register and a
// second verdict waits in the prep register; input stalls only while both
// are full, so bytes keep flowing until two verdicts are pending.
module container_header_validator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // [2:0] status, [7:3] error_offset,
                                       // [15:8] format_version, [23:16] hdr_flags,
                                       // [39:24] section_total, [71:40] directory_bytes,
                                       // [103:72] file_ident
);

  // Parse state
  logic [chv_pkg::IDX_W-1:0] byte_index;
  logic [191:0]              hdr;
  logic [31:0]               header_hash;
  logic [31:0]               body_hash;
  logic [31:0]               header_fin;
  chv_pkg::status_t          first_error;

  logic [chv_pkg::IDX_W-1:0] byte_index_next;
  logic [191:0]              hdr_next;
  logic [31:0]               header_hash_next;
  logic [31:0]               body_hash_next;
  chv_pkg::status_t          first_error_next;

  // Prep stage
  logic                      p_valid;
  chv_pkg::status_t          p_status;
  logic [4:0]                p_offset;
  logic                      p_need_body;
  logic [31:0]               p_body_hash;
  logic [31:0]               p_body_sum;
  logic [95:0]               p_fields;

  chv_pkg::status_t          pre_status;
  logic [4:0]                pre_offset;
  logic                      pre_need_body;

  // Output stage
  chv_pkg::status_t          out_status;
  logic [4:0]                out_offset;
  logic [95:0]               out_fields;

  logic                      s_fire;
  logic                      p_adv;
  logic [31:0]               dir;
  logic [7:0]                b;
  logic [chv_pkg::IDX_W:0]   dir_end;
  chv_pkg::status_t          fin_status;
  logic [4:0]                fin_offset;

  assign b      = s_axis_tdata;
  assign p_adv  = p_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !p_valid || p_adv;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Byte update: capture, hashes, header checks
  always_comb begin
    hdr_next = hdr;
    if (byte_index < chv_pkg::HDR_LEN) begin
      hdr_next[byte_index[4:0]*8 +: 8] = b;
    end
    dir = hdr_next[95:64];

    header_hash_next = header_hash;
    if (byte_index < chv_pkg::HASHED_LEN) begin
      header_hash_next = chv_pkg::fnv_mix(header_hash, {24'd0, b});
    end

    body_hash_next = body_hash;
    if (byte_index >= chv_pkg::HDR_LEN &&
        (byte_index - chv_pkg::HDR_LEN) < {1'b0, dir}) begin
      body_hash_next = chv_pkg::fnv_mix(body_hash, {24'd0, b});
    end

    first_error_next = first_error;
    if (first_error == chv_pkg::ST_OK) begin
      if (byte_index == chv_pkg::POS_MAGIC && hdr_next[31:0] != chv_pkg::MAGIC_WORD) begin
        first_error_next = chv_pkg::ST_MAGIC;
      end else if (byte_index == chv_pkg::POS_VERSION &&
                   (hdr_next[39:32] == 8'd0 || hdr_next[39:32] > chv_pkg::MAX_VERSION)) begin
        first_error_next = chv_pkg::ST_VERSION;
      end else if (byte_index == chv_pkg::POS_SECTIONS &&
                   hdr_next[63:48] > chv_pkg::MAX_SECTIONS) begin
        first_error_next = chv_pkg::ST_LENGTH;
      end else if (byte_index == chv_pkg::POS_HDR_SUM &&
                   header_fin != hdr_next[191:160]) begin
        first_error_next = chv_pkg::ST_HDR_SUM;
      end
    end

    byte_index_next = (byte_index == chv_pkg::IDX_MAX) ? byte_index : byte_index + 1'b1;
  end

  // Verdict up to the body checksum
  always_comb begin
    dir_end       = {1'b0, chv_pkg::HDR_LEN} + {2'b00, dir};
    pre_need_body = 1'b0;
    pre_status    = chv_pkg::ST_OK;
    pre_offset    = chv_pkg::OFS_NONE;
    if (byte_index_next < chv_pkg::HDR_LEN) begin
      pre_status = chv_pkg::ST_EOF;
    end else begin
      case (first_error_next)
        chv_pkg::ST_MAGIC: begin
          pre_status = chv_pkg::ST_MAGIC;
        end
        chv_pkg::ST_VERSION: begin
          pre_status = chv_pkg::ST_VERSION;
          pre_offset = chv_pkg::OFS_VERSION;
        end
        chv_pkg::ST_LENGTH: begin
          pre_status = chv_pkg::ST_LENGTH;
          pre_offset = chv_pkg::OFS_SECTIONS;
        end
        chv_pkg::ST_OK: begin
          if (dir_end > {1'b0, byte_index_next}) begin
            pre_status = chv_pkg::ST_LENGTH;
            pre_offset = chv_pkg::OFS_DIR_LEN;
          end else begin
            pre_need_body = hdr_next[40];
          end
        end
        default: begin
          pre_status = chv_pkg::ST_HDR_SUM;
          pre_offset = chv_pkg::OFS_HDR_SUM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      hdr         <= '0;
      header_hash <= chv_pkg::FNV_BASIS;
      body_hash   <= chv_pkg::FNV_BASIS;
      first_error <= chv_pkg::ST_OK;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        // Drop all parse state; next beat starts a new file
        byte_index  <= '0;
        hdr         <= '0;
        header_hash <= chv_pkg::FNV_BASIS;
        body_hash   <= chv_pkg::FNV_BASIS;
        first_error <= chv_pkg::ST_OK;
      end else begin
        byte_index  <= byte_index_next;
        hdr         <= hdr_next;
        header_hash <= header_hash_next;
        body_hash   <= body_hash_next;
        first_error <= first_error_next;
      end
    end
  end

  // Finished header hash; settles well before byte 23 arrives
  always_ff @(posedge clk) begin
    header_fin <= chv_pkg::fnv_mix(header_hash, chv_pkg::HASHED_LEN_WORD);
  end

  // Prep register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      p_valid <= 1'b1;
    end else if (p_adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tlast) begin
      p_status    <= pre_status;
      p_offset    <= pre_offset;
      p_need_body <= pre_need_body;
      p_body_hash <= body_hash_next ^ dir;
      p_body_sum  <= hdr_next[159:128];
      p_fields    <= hdr_next[127:32];
    end
  end

  // Fold directory size into body hash and compare
  always_comb begin
    fin_status = p_status;
    fin_offset = p_offset;
    if (p_need_body && (p_body_hash * chv_pkg::FNV_PRIME) != p_body_sum) begin
      fin_status = chv_pkg::ST_BODY_SUM;
      fin_offset = chv_pkg::OFS_BODY_SUM;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv) begin
      out_status <= fin_status;
      out_offset <= fin_offset;
      out_fields <= p_fields;
    end
  end

  assign m_axis_tdata = {out_fields, out_offset, out_status};

  // A pending verdict in the prep stage is never lost while the output stalls
  a_prep_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_adv |=> p_valid)
    else $error("prep verdict dropped while stalled");

  // The final byte always restarts the byte count
  a_restart: assert property (@(posedge clk) disable iff (rst)
    s_fire && s_axis_tlast |=> byte_index == '0 && first_error == chv_pkg::ST_OK)
    else $error("parse state not cleared after final byte");

  // Header hash frozen once the hashed header bytes are in
  a_hdr_hash_frozen: assert property (@(posedge clk) disable iff (rst)
    byte_index >= chv_pkg::HASHED_LEN && !(s_fire && s_axis_tlast)
    |=> $stable(header_hash))
    else $error("header hash changed past hashed range");

  // An ok verdict reports offset zero
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status == chv_pkg::ST_OK |-> out_offset == chv_pkg::OFS_NONE)
    else $error("ok verdict with nonzero offset");

  // No new verdict enters the prep stage while it still holds one that cannot move
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_adv |-> !s_fire)
    else $error("input accepted over stalled prep verdict");

endmodule
